// ===== hdl/line_follow_obstacle_controller_macros.svh =====
// ----------------------------------------------------------------------------
// line follower controller assertion macros
// shared property forms for same-cycle and next-cycle checks
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_OBSTACLE_CONTROLLER_MACROS_SVH
`define LINE_FOLLOW_OBSTACLE_CONTROLLER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LFOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LFOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lfoc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfoc_pkg
// types and constants of the line follower controller with obstacle stop
// ----------------------------------------------------------------------------
package lfoc_pkg;

  localparam int DUTY_W  = 10;
  localparam int DIST_W  = 12;
  localparam int TIME_W  = 16;
  localparam int TRIG_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // distance = floor(width * 46 / 1000) = (width * DIST_RECIP) >> DIST_SHIFT
  localparam int DIST_SHIFT = 25;
  localparam int RECIP_W    = 21;
  localparam logic [RECIP_W-1:0] DIST_RECIP = 21'd1543504;
  localparam int PROD_W     = TIME_W + RECIP_W;

  localparam logic [DIST_W-1:0] DIST_RESET = 12'd999;

  typedef enum logic [2:0] {
    MODE_STOP     = 3'd0,
    MODE_FORWARD  = 3'd1,
    MODE_LEFT     = 3'd2,
    MODE_RIGHT    = 3'd3,
    MODE_OBSTACLE = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FWD_RIGHT = 3'd0,
    CFG_FWD_LEFT  = 3'd1,
    CFG_TURN_FAST = 3'd2,
    CFG_TURN_SLOW = 3'd3,
    CFG_OBST_LIM  = 3'd4,
    CFG_TRIG_PER  = 3'd5
  } cfg_idx_t;

  localparam logic KIND_CAPTURE = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef struct packed {
    logic              capture_en;
    logic              tick_en;
    logic [TIME_W-1:0] capture_time;
  } range_ev_t;

endpackage

// ===== hdl/lfoc_ranger.sv =====
// ----------------------------------------------------------------------------
// lfoc_ranger
// echo edge pairing, pulse width capture and distance conversion
// ----------------------------------------------------------------------------
module lfoc_ranger (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lfoc_pkg::range_ev_t       ev,
  output logic [lfoc_pkg::DIST_W-1:0] distance_now
);
  import lfoc_pkg::*;

  logic [TIME_W-1:0] edge_start_r;
  logic [TIME_W-1:0] pulse_width_r;
  logic              awaiting_end_r;
  logic              pulse_pending_r;
  logic [DIST_W-1:0] distance_r;
  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] dist_calc;

  assign prod      = {{RECIP_W{1'b0}}, pulse_width_r} * {{TIME_W{1'b0}}, DIST_RECIP};
  assign dist_calc = prod[DIST_SHIFT +: DIST_W];
  assign distance_now = pulse_pending_r ? dist_calc : distance_r;

  always_ff @(posedge clk) begin
    if (ev.capture_en) begin
      if (!awaiting_end_r) begin
        edge_start_r <= ev.capture_time;
      end else begin
        pulse_width_r <= ev.capture_time - edge_start_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_end_r  <= 1'b0;
      pulse_pending_r <= 1'b0;
      distance_r      <= DIST_RESET;
    end else if (ev.capture_en) begin
      awaiting_end_r <= !awaiting_end_r;
      if (awaiting_end_r) begin
        pulse_pending_r <= 1'b1;
      end
    end else if (ev.tick_en && pulse_pending_r) begin
      distance_r      <= dist_calc;
      pulse_pending_r <= 1'b0;
    end
  end

endmodule

// ===== hdl/line_follow_obstacle_controller.sv =====
// an item is registered in the input register, and a tick's result is then registered
// in the result register; a tick waits while a result is held and out_tready is low
// throughput: one item per cycle unless a tick waits on a held result; the pulse width
// times reciprocal multiply on the distance path into the mode compare sets the cycle
// reset (rst_n low, synchronous): control and config registers to defaults, distance 999, no result held
// ----------------------------------------------------------------------------
// line_follow_obstacle_controller
// line follower mode control with ultrasonic obstacle stop and trigger divider
// ----------------------------------------------------------------------------
`include "line_follow_obstacle_controller_macros.svh"

module line_follow_obstacle_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lfoc_pkg::IN_DATA_W-1:0]      in_tdata,   // capture_time, left_level, right_level
  input  logic                                in_tuser,   // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lfoc_pkg::OUT_DATA_W-1:0]     out_tdata,  // left_duty, right_duty, blue_led,
                                                          // green_led, trigger_fire, mode,
                                                          // distance_now
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lfoc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfoc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lfoc_pkg::*;

  logic [DUTY_W-1:0] fwd_right_r, fwd_left_r, turn_fast_r, turn_slow_r;
  logic [DIST_W-1:0] obst_lim_r;
  logic [TRIG_W-1:0] trig_per_r;
  logic [TRIG_W-1:0] trig_cnt_r;

  logic              s1_valid_r;
  logic              s1_kind_r;
  logic [TIME_W-1:0] s1_time_r;
  logic              s1_left_r, s1_right_r;
  logic              s1_adv;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  range_ev_t         ev;
  logic [DIST_W-1:0] dist_now;
  logic              fire;
  logic              line_l, line_r;
  mode_t             mode;
  logic [DUTY_W-1:0] ltd, rtd;
  logic              blue, green;

  // config writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_right_r <= 10'd1000;
      fwd_left_r  <= 10'd912;
      turn_fast_r <= 10'd750;
      turn_slow_r <= 10'd550;
      obst_lim_r  <= 12'd20;
      trig_per_r  <= 8'd5;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FWD_RIGHT: fwd_right_r <= cfg_data[DUTY_W-1:0];
        CFG_FWD_LEFT:  fwd_left_r  <= cfg_data[DUTY_W-1:0];
        CFG_TURN_FAST: turn_fast_r <= cfg_data[DUTY_W-1:0];
        CFG_TURN_SLOW: turn_slow_r <= cfg_data[DUTY_W-1:0];
        CFG_OBST_LIM:  obst_lim_r  <= cfg_data[DIST_W-1:0];
        CFG_TRIG_PER:  trig_per_r  <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign s1_adv    = s1_valid_r && (s1_kind_r == KIND_CAPTURE || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r  <= in_tuser;
      s1_time_r  <= in_tdata[TIME_W-1:0];
      s1_left_r  <= in_tdata[TIME_W];
      s1_right_r <= in_tdata[TIME_W+1];
    end
  end

  // ranging
  assign ev.capture_en   = s1_adv && s1_kind_r == KIND_CAPTURE;
  assign ev.tick_en      = s1_adv && s1_kind_r == KIND_TICK;
  assign ev.capture_time = s1_time_r;

  lfoc_ranger u_ranger (
    .clk          (clk),
    .rst_n        (rst_n),
    .ev           (ev),
    .distance_now (dist_now)
  );

  // trigger divider
  assign fire = trig_cnt_r >= trig_per_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_cnt_r <= '0;
    end else if (ev.tick_en) begin
      trig_cnt_r <= fire ? '0 : trig_cnt_r + 8'd1;
    end
  end

  // mode choice
  assign line_l = !s1_left_r;
  assign line_r = !s1_right_r;

  always_comb begin
    priority if (dist_now != '0 && dist_now <= obst_lim_r) begin
      mode = MODE_OBSTACLE; ltd = '0; rtd = '0; blue = 1'b1; green = 1'b1;
    end else if (line_l && line_r) begin
      mode = MODE_FORWARD; ltd = fwd_left_r; rtd = fwd_right_r; blue = 1'b1; green = 1'b1;
    end else if (line_l) begin
      mode = MODE_RIGHT; ltd = turn_fast_r; rtd = turn_slow_r; blue = 1'b0; green = 1'b1;
    end else if (line_r) begin
      mode = MODE_LEFT; ltd = turn_slow_r; rtd = turn_fast_r; blue = 1'b1; green = 1'b0;
    end else begin
      mode = MODE_STOP; ltd = '0; rtd = '0; blue = 1'b0; green = 1'b0;
    end
  end

  assign out_data_nxt = {2'b00, dist_now, mode, fire, green, blue, rtd, ltd};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ev.tick_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.tick_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `LFOC_ASSERT_NOW(a_obst_stops, out_valid_r && out_data_r[25:23] == MODE_OBSTACLE,
    out_data_r[19:0] == '0, "obstacle result with nonzero duty")
  `LFOC_ASSERT_NEXT(a_fire_clears, ev.tick_en && fire, trig_cnt_r == '0,
    "trigger count not cleared after fire")
  `LFOC_ASSERT_NEXT(a_capture_silent, ev.capture_en && out_tready,
    !out_valid_r, "capture edge produced a result")
  `LFOC_ASSERT_NOW(a_dist_range, out_valid_r, out_data_r[37:26] <= 12'd3014,
    "distance out of range")

endmodule
